/* hw/rtl/qvr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, register indexes and payload types for the quaternion
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int VEC_W     = 16;   // vector component width
    localparam int QUAT_W    = 16;   // Q2.14 quaternion component width
    localparam int PROD1_W   = VEC_W + QUAT_W;      // v * q product
    localparam int T_W       = PROD1_W + 2;         // sum of three products
    localparam int PROD2_W   = T_W + QUAT_W;        // q * t product
    localparam int R_W       = PROD2_W + 2;         // sum of four products
    localparam int FRAC_SHIFT = 28;                  // two Q2.14 scalings
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = CFG_IDX_W'(3);

    localparam logic [QUAT_W-1:0] QUAT_ONE = QUAT_W'(16384);

    typedef struct packed {
        logic [QUAT_W-1:0] w;
        logic [QUAT_W-1:0] x;
        logic [QUAT_W-1:0] y;
        logic [QUAT_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic [VEC_W-1:0] x;
        logic [VEC_W-1:0] y;
        logic [VEC_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic [T_W-1:0] x;
        logic [T_W-1:0] y;
        logic [T_W-1:0] z;
        logic [T_W-1:0] w;
    } t_tquat;

    typedef struct packed {
        logic [R_W-1:0] x;
        logic [R_W-1:0] y;
        logic [R_W-1:0] z;
    } t_rvec;

endpackage

/* hw/rtl/qvr_tprod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_tprod
// First Hamilton product t = (v, 0) * conj(q): registered products, then
// registered sums. Two stages.
// ----------------------------------------------------------------------------
module qvr_tprod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  qvr_pkg::t_vec   i_vec,
    input  qvr_pkg::t_quat  i_quat,
    output logic            o_valid,
    output qvr_pkg::t_tquat o_t
);

    localparam int PW = qvr_pkg::PROD1_W;
    localparam int TW = qvr_pkg::T_W;

    logic signed [qvr_pkg::VEC_W-1:0]  vx, vy, vz;
    logic signed [qvr_pkg::QUAT_W-1:0] qw, qx, qy, qz;
    logic signed [PW-1:0] r_p [12];
    logic                 r_v1;
    logic signed [TW-1:0] n_tx, n_ty, n_tz, n_tw;
    logic                 r_v2;
    qvr_pkg::t_tquat      r_t;

    assign vx = $signed(i_vec.x);
    assign vy = $signed(i_vec.y);
    assign vz = $signed(i_vec.z);
    assign qw = $signed(i_quat.w);
    assign qx = $signed(i_quat.x);
    assign qy = $signed(i_quat.y);
    assign qz = $signed(i_quat.z);

    always_ff @(posedge i_clk) begin
        r_p[0]  <= PW'(vx) * PW'(qw);
        r_p[1]  <= PW'(vy) * PW'(qz);
        r_p[2]  <= PW'(vz) * PW'(qy);
        r_p[3]  <= PW'(vy) * PW'(qw);
        r_p[4]  <= PW'(vz) * PW'(qx);
        r_p[5]  <= PW'(vx) * PW'(qz);
        r_p[6]  <= PW'(vz) * PW'(qw);
        r_p[7]  <= PW'(vx) * PW'(qy);
        r_p[8]  <= PW'(vy) * PW'(qx);
        r_p[9]  <= PW'(vx) * PW'(qx);
        r_p[10] <= PW'(vy) * PW'(qy);
        r_p[11] <= PW'(vz) * PW'(qz);
    end

    always_comb begin
        n_tx = TW'(r_p[0]) - TW'(r_p[1])  + TW'(r_p[2]);
        n_ty = TW'(r_p[3]) - TW'(r_p[4])  + TW'(r_p[5]);
        n_tz = TW'(r_p[6]) - TW'(r_p[7])  + TW'(r_p[8]);
        n_tw = TW'(r_p[9]) + TW'(r_p[10]) + TW'(r_p[11]);
    end

    always_ff @(posedge i_clk) begin
        r_t.x <= n_tx;
        r_t.y <= n_ty;
        r_t.z <= n_tz;
        r_t.w <= n_tw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_t     = r_t;

endmodule

/* hw/rtl/qvr_rprod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_rprod
// Second Hamilton product r = q * t, vector part: registered 16x34
// products, then registered sums. Two stages.
// ----------------------------------------------------------------------------
module qvr_rprod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  qvr_pkg::t_tquat i_t,
    input  qvr_pkg::t_quat  i_quat,
    output logic            o_valid,
    output qvr_pkg::t_rvec  o_r
);

    localparam int PW = qvr_pkg::PROD2_W;
    localparam int RW = qvr_pkg::R_W;

    logic signed [qvr_pkg::T_W-1:0]    tx, ty, tz, tw;
    logic signed [qvr_pkg::QUAT_W-1:0] qw, qx, qy, qz;
    logic signed [PW-1:0] r_p [12];
    logic                 r_v1;
    logic signed [RW-1:0] n_rx, n_ry, n_rz;
    logic                 r_v2;
    qvr_pkg::t_rvec       r_r;

    assign tx = $signed(i_t.x);
    assign ty = $signed(i_t.y);
    assign tz = $signed(i_t.z);
    assign tw = $signed(i_t.w);
    assign qw = $signed(i_quat.w);
    assign qx = $signed(i_quat.x);
    assign qy = $signed(i_quat.y);
    assign qz = $signed(i_quat.z);

    always_ff @(posedge i_clk) begin
        r_p[0]  <= PW'(qw) * PW'(tx);
        r_p[1]  <= PW'(qx) * PW'(tw);
        r_p[2]  <= PW'(qy) * PW'(tz);
        r_p[3]  <= PW'(qz) * PW'(ty);
        r_p[4]  <= PW'(qw) * PW'(ty);
        r_p[5]  <= PW'(qy) * PW'(tw);
        r_p[6]  <= PW'(qz) * PW'(tx);
        r_p[7]  <= PW'(qx) * PW'(tz);
        r_p[8]  <= PW'(qw) * PW'(tz);
        r_p[9]  <= PW'(qz) * PW'(tw);
        r_p[10] <= PW'(qx) * PW'(ty);
        r_p[11] <= PW'(qy) * PW'(tx);
    end

    always_comb begin
        n_rx = RW'(r_p[0]) + RW'(r_p[1]) + RW'(r_p[2])  - RW'(r_p[3]);
        n_ry = RW'(r_p[4]) + RW'(r_p[5]) + RW'(r_p[6])  - RW'(r_p[7]);
        n_rz = RW'(r_p[8]) + RW'(r_p[9]) + RW'(r_p[10]) - RW'(r_p[11]);
    end

    always_ff @(posedge i_clk) begin
        r_r.x <= n_rx;
        r_r.y <= n_ry;
        r_r.z <= n_rz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_r     = r_r;

endmodule

/* hw/rtl/qvr_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_round
// Output stage: round-half-up shift by 2^28, saturate each component to
// 16 bits, flag any saturation. One register stage.
// ----------------------------------------------------------------------------
module qvr_round (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  qvr_pkg::t_rvec             i_r,
    output logic                       o_valid,
    output logic [qvr_pkg::VEC_W-1:0]  o_x,
    output logic [qvr_pkg::VEC_W-1:0]  o_y,
    output logic [qvr_pkg::VEC_W-1:0]  o_z,
    output logic                       o_clip
);

    localparam int RW = qvr_pkg::R_W;
    localparam int EW = RW + 1;
    localparam int VW = qvr_pkg::VEC_W;
    localparam logic signed [EW-1:0] HALF   = EW'(1) <<< (qvr_pkg::FRAC_SHIFT - 1);
    localparam logic signed [EW-1:0] MAXV   = EW'((1 << (VW - 1)) - 1);
    localparam logic signed [EW-1:0] MINV   = -EW'(1 << (VW - 1));

    typedef struct packed {
        logic [VW-1:0] val;
        logic          sat;
    } t_sat;

    function automatic t_sat round_sat(input logic [RW-1:0] v);
        logic signed [EW-1:0] s;
        t_sat res;
        s = (EW'($signed(v)) + HALF) >>> qvr_pkg::FRAC_SHIFT;
        if (s > MAXV) begin
            res.val = MAXV[VW-1:0];
            res.sat = 1'b1;
        end else if (s < MINV) begin
            res.val = MINV[VW-1:0];
            res.sat = 1'b1;
        end else begin
            res.val = s[VW-1:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

    t_sat n_x, n_y, n_z;
    logic [VW-1:0] r_x, r_y, r_z;
    logic          r_clip;
    logic          r_valid;

    always_comb begin
        n_x = round_sat(i_r.x);
        n_y = round_sat(i_r.y);
        n_z = round_sat(i_r.z);
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x.val;
        r_y    <= n_y.val;
        r_z    <= n_z.val;
        r_clip <= n_x.sat | n_y.sat | n_z.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_clip  = r_clip;

endmodule

/* hw/rtl/quaternion_vector_rotation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotation
// Rotates a signed 16-bit 3-vector by a configured Q2.14 quaternion,
// r = q * (v, 0) * conj(q), full precision, rounded and saturated.
// ----------------------------------------------------------------------------
// One vector is accepted per clock (busy is never raised) and its result
// appears on o_done for one cycle only; the receiver must take it then. The
// result passes through six register stages: input capture, two stages each
// for the two multiplier banks of the Hamilton products, and the round/saturate
// stage. Quaternion registers reset to the identity and may be written only
// while no vector is in flight.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [qvr_pkg::VEC_W-1:0]       i_vec_x,
    input  logic [qvr_pkg::VEC_W-1:0]       i_vec_y,
    input  logic [qvr_pkg::VEC_W-1:0]       i_vec_z,
    output logic                            o_done,
    output logic [qvr_pkg::VEC_W-1:0]       o_rot_x,
    output logic [qvr_pkg::VEC_W-1:0]       o_rot_y,
    output logic [qvr_pkg::VEC_W-1:0]       o_rot_z,
    output logic                            o_clipped,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qvr_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    qvr_pkg::t_quat  r_quat;
    qvr_pkg::t_vec   r_vec;
    logic            r_v0;
    logic            t_valid;
    qvr_pkg::t_tquat t_val;
    logic            r_valid;
    qvr_pkg::t_rvec  r_val;
    logic            cfg_xfer;
    logic            acc;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= qvr_pkg::QUAT_ONE;
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                qvr_pkg::REG_QUAT_W: r_quat.w <= i_cfg_data;
                qvr_pkg::REG_QUAT_X: r_quat.x <= i_cfg_data;
                qvr_pkg::REG_QUAT_Y: r_quat.y <= i_cfg_data;
                qvr_pkg::REG_QUAT_Z: r_quat.z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_vec.x <= i_vec_x;
            r_vec.y <= i_vec_y;
            r_vec.z <= i_vec_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= acc;
        end
    end

    qvr_tprod u_tprod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_vec   (r_vec),
        .i_quat  (r_quat),
        .o_valid (t_valid),
        .o_t     (t_val)
    );

    qvr_rprod u_rprod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (t_valid),
        .i_t     (t_val),
        .i_quat  (r_quat),
        .o_valid (r_valid),
        .o_r     (r_val)
    );

    qvr_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid),
        .i_r     (r_val),
        .o_valid (o_done),
        .o_x     (o_rot_x),
        .o_y     (o_rot_y),
        .o_z     (o_rot_z),
        .o_clip  (o_clipped)
    );

    // every accepted vector yields exactly one result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##6 o_done)
        else $error("result strobe missing after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(acc, 6))
        else $error("result strobe without matching transfer");

    // a clip flag implies some component sits at a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_clipped) |->
            (o_rot_x == 16'h7fff || o_rot_x == 16'h8000 ||
             o_rot_y == 16'h7fff || o_rot_y == 16'h8000 ||
             o_rot_z == 16'h7fff || o_rot_z == 16'h8000))
        else $error("clip flag set with no saturated component");

endmodule

/* tb/qvr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_checker
// Watches the vector, result and register channels of the quaternion
// rotation block. Keeps its own copy of the quaternion registers, predicts
// the rotated vector for every accepted input transfer and compares each
// result strobe, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module qvr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [qvr_pkg::VEC_W-1:0]     i_vec_x,
    input  logic [qvr_pkg::VEC_W-1:0]     i_vec_y,
    input  logic [qvr_pkg::VEC_W-1:0]     i_vec_z,
    input  logic                          i_done,
    input  logic [qvr_pkg::VEC_W-1:0]     i_rot_x,
    input  logic [qvr_pkg::VEC_W-1:0]     i_rot_y,
    input  logic [qvr_pkg::VEC_W-1:0]     i_rot_z,
    input  logic                          i_clipped,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [qvr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qvr_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int     VW         = qvr_pkg::VEC_W;
    localparam int     FS         = qvr_pkg::FRAC_SHIFT;
    localparam longint ROUND_HALF = longint'(1) <<< (FS - 1);
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic [VW-1:0] x;
        logic [VW-1:0] y;
        logic [VW-1:0] z;
        logic          clip;
    } t_rot_expect;

    qvr_pkg::t_quat quat_regs;
    t_rot_expect    rot_expected_q[$];
    int             fail_count = 0;
    int             pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    // q * (v, 0) * conj(q) at full precision, then round-half-up and saturate
    function automatic t_rot_expect rotate_vec(input qvr_pkg::t_vec v,
                                               input qvr_pkg::t_quat q);
        longint        vx, vy, vz, qw, qx, qy, qz;
        longint        tx, ty, tz, tw;
        longint        r[3];
        logic [VW-1:0] c[3];
        t_rot_expect   res;
        vx = longint'($signed(v.x));
        vy = longint'($signed(v.y));
        vz = longint'($signed(v.z));
        qw = longint'($signed(q.w));
        qx = longint'($signed(q.x));
        qy = longint'($signed(q.y));
        qz = longint'($signed(q.z));
        tx = vx * qw - vy * qz + vz * qy;
        ty = vy * qw - vz * qx + vx * qz;
        tz = vz * qw - vx * qy + vy * qx;
        tw = vx * qx + vy * qy + vz * qz;
        r[0] = qw * tx + qx * tw + qy * tz - qz * ty;
        r[1] = qw * ty + qy * tw + qz * tx - qx * tz;
        r[2] = qw * tz + qz * tw + qx * ty - qy * tx;
        res.clip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            r[k] = (r[k] + ROUND_HALF) >>> FS;
            if (r[k] > 32767) begin
                c[k] = 16'h7FFF;
                res.clip = 1'b1;
            end else if (r[k] < -32768) begin
                c[k] = 16'h8000;
                res.clip = 1'b1;
            end else begin
                c[k] = VW'(r[k]);
            end
        end
        res.x = c[0];
        res.y = c[1];
        res.z = c[2];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rot_expect   exp_rot;
        t_rot_expect   act_rot;
        qvr_pkg::t_vec vin;
        if (!i_rst_n) begin
            quat_regs.w = qvr_pkg::QUAT_ONE;
            quat_regs.x = '0;
            quat_regs.y = '0;
            quat_regs.z = '0;
            rot_expected_q.delete();
        end else begin
            if (i_done) begin
                act_rot.x    = i_rot_x;
                act_rot.y    = i_rot_y;
                act_rot.z    = i_rot_z;
                act_rot.clip = i_clipped;
                if (rot_expected_q.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("ERROR: unexpected result x=%h y=%h z=%h clip=%b",
                                 i_rot_x, i_rot_y, i_rot_z, i_clipped);
                    fail_count++;
                end else begin
                    exp_rot = rot_expected_q.pop_front();
                    if (act_rot !== exp_rot) begin
                        if (fail_count < REPORT_MAX)
                            $display("ERROR: exp %h %h %h %b act %h %h %h %b",
                                     exp_rot.x, exp_rot.y, exp_rot.z, exp_rot.clip,
                                     act_rot.x, act_rot.y, act_rot.z, act_rot.clip);
                        fail_count++;
                    end
                end
            end
            // vector transfer uses the registers as they stand before this edge
            if (i_start && !i_busy) begin
                vin.x = i_vec_x;
                vin.y = i_vec_y;
                vin.z = i_vec_z;
                rot_expected_q.push_back(rotate_vec(vin, quat_regs));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    qvr_pkg::REG_QUAT_W: quat_regs.w = i_cfg_data;
                    qvr_pkg::REG_QUAT_X: quat_regs.x = i_cfg_data;
                    qvr_pkg::REG_QUAT_Y: quat_regs.y = i_cfg_data;
                    qvr_pkg::REG_QUAT_Z: quat_regs.z = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_cnt = rot_expected_q.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the quaternion vector rotation block. Runs a
// directed set of edge vectors and quaternions, then random blocks of
// vectors under changing quaternion settings and sender idle rates; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int            VW             = qvr_pkg::VEC_W;
    localparam int            IW             = qvr_pkg::CFG_IDX_W;
    localparam int            DW             = qvr_pkg::CFG_DAT_W;
    localparam int            WATCHDOG_LIMIT = 2000;
    localparam int            RAND_BLOCKS    = 25;
    localparam int            BLOCK_ITEMS    = 50;
    localparam logic [IW-1:0] REG_STRAY_TOP  = IW'(255);

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [VW-1:0] vec_x, vec_y, vec_z;
    logic          done;
    logic [VW-1:0] rot_x, rot_y, rot_z;
    logic          clipped;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [IW-1:0] cfg_index;
    logic [DW-1:0] cfg_data;
    int            fail_count;
    int            pending;
    int            send_idle_pct;
    int            quiet_cycles = 0;

    quaternion_vector_rotation u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_vec_x     (vec_x),
        .i_vec_y     (vec_y),
        .i_vec_z     (vec_z),
        .o_done      (done),
        .o_rot_x     (rot_x),
        .o_rot_y     (rot_y),
        .o_rot_z     (rot_z),
        .o_clipped   (clipped),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    qvr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_vec_x      (vec_x),
        .i_vec_y      (vec_y),
        .i_vec_z      (vec_z),
        .i_done       (done),
        .i_rot_x      (rot_x),
        .i_rot_y      (rot_y),
        .i_rot_z      (rot_z),
        .i_clipped    (clipped),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ends the run when no transfer of any kind happens for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL quaternion_vector_rotation");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] pick_extreme();
        logic [15:0] val;
        case ($urandom_range(4))
            0:       val = 16'h8000;
            1:       val = 16'h7FFF;
            2:       val = 16'h0000;
            3:       val = 16'hFFFF;
            default: val = 16'h4000;
        endcase
        return val;
    endfunction

    // entered and left at a falling edge; start is left high after a transfer
    task automatic push_vector(input logic [VW-1:0] x, y, z);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // waits for every vector in flight to come out, then loads all four parts
    task automatic load_quat(input logic [15:0] w, x, y, z, input bit stray,
                             input logic [IW-1:0] stray_idx);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        write_reg(qvr_pkg::REG_QUAT_W, w);
        write_reg(qvr_pkg::REG_QUAT_X, x);
        write_reg(qvr_pkg::REG_QUAT_Y, y);
        write_reg(qvr_pkg::REG_QUAT_Z, z);
        if (stray)
            write_reg(stray_idx, DW'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        real         qa[4];
        real         nrm;
        logic [15:0] qv[4];
        logic [15:0] rv[3];
        start         <= 1'b0;
        vec_x         <= '0;
        vec_y         <= '0;
        vec_z         <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        send_idle_pct = 33;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity from reset
        push_vector(16'h0000, 16'h0000, 16'h0000);
        push_vector(16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_vector(16'h8000, 16'h8000, 16'h8000);
        push_vector(16'h7FFF, 16'h8000, 16'h0001);
        push_vector(16'hFFFF, 16'h0000, 16'h0001);
        // quarter turn about z
        load_quat(16'd11585, 16'd0, 16'd0, 16'd11585, 1'b0, '0);
        push_vector(16'h4000, 16'h0000, 16'h0000);
        push_vector(16'h7FFF, 16'h8000, 16'h1234);
        // largest non-unit quaternion, heavy saturation
        load_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0);
        push_vector(16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_vector(16'h8000, 16'h7FFF, 16'h8000);
        push_vector(16'h0001, 16'h0001, 16'h0001);
        load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0);
        push_vector(16'h8000, 16'h8000, 16'h8000);
        push_vector(16'h7FFF, 16'h0000, 16'h0000);
        push_vector(16'hFFFF, 16'hFFFF, 16'hFFFF);
        // scalar -2.0: scales by four
        load_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
        push_vector(16'h4000, 16'hC000, 16'h0001);
        push_vector(16'h7FFF, 16'h0000, 16'h0000);
        push_vector(16'h0001, 16'h0002, 16'h0003);
        // half turn about x, plus an ignored write to the top index
        load_quat(16'd0, 16'd16384, 16'd0, 16'd0, 1'b1, REG_STRAY_TOP);
        push_vector(16'h0001, 16'h0002, 16'h0003);
        push_vector(16'h8000, 16'h8000, 16'h8000);
        // scalar 0.5 squared is 2^26: exact halves round up
        load_quat(16'd8192, 16'd0, 16'd0, 16'd0, 1'b0, '0);
        push_vector(16'h0002, 16'hFFFE, 16'h0001);
        push_vector(16'hFFFA, 16'h0006, 16'h0003);

        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            send_idle_pct = (blk < 9) ? 33 : (blk < 17) ? 55 : 0;
            case ($urandom_range(9))
                7: begin
                    for (int k = 0; k < 4; k++) qv[k] = 16'($urandom);
                end
                8, 9: begin
                    for (int k = 0; k < 4; k++) qv[k] = pick_extreme();
                end
                default: begin
                    nrm = 0.0;
                    for (int k = 0; k < 4; k++) begin
                        qa[k] = real'(int'($urandom_range(32768)) - 16384);
                        nrm = nrm + qa[k] * qa[k];
                    end
                    nrm = $sqrt(nrm);
                    if (nrm < 1.0) begin
                        qv[0] = qvr_pkg::QUAT_ONE;
                        for (int k = 1; k < 4; k++) qv[k] = '0;
                    end else begin
                        for (int k = 0; k < 4; k++)
                            qv[k] = 16'($rtoi(qa[k] * 16384.0 / nrm));
                    end
                end
            endcase
            load_quat(qv[0], qv[1], qv[2], qv[3], ($urandom_range(3) == 0),
                      IW'($urandom_range(4, 255)));
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                case ($urandom_range(9))
                    0: begin
                        for (int k = 0; k < 3; k++) rv[k] = pick_extreme();
                    end
                    1: begin
                        for (int k = 0; k < 3; k++)
                            rv[k] = 16'(int'($urandom_range(512)) - 256);
                    end
                    default: begin
                        for (int k = 0; k < 3; k++) rv[k] = 16'($urandom);
                    end
                endcase
                push_vector(rv[0], rv[1], rv[2]);
            end
        end

        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS quaternion_vector_rotation");
        else
            $display("FAIL quaternion_vector_rotation");
        $finish;
    end

endmodule
